// File: rtl/pmws_pkg.sv
package pmws_pkg;

	localparam int MAX_MOTIF_LEN = 32;
	localparam int MAX_ALPHABET  = 8;

	localparam int POS_W   = 5;
	localparam int SYM_W   = 3;
	localparam int WGT_W   = 16;
	localparam int SUM_W   = 21;
	localparam int KLEN_W  = 6;
	localparam int ALPHA_W = 4;
	localparam int CFG_W   = 6;

	localparam logic signed [SUM_W-1:0] NEG_INF  = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [WGT_W-1:0] LOG_ZERO = {1'b1, {(WGT_W-1){1'b0}}};

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SYMBOL = 1'b1
	} opcode_t;

	typedef enum logic {
		CFG_MOTIF_LENGTH  = 1'b0,
		CFG_ALPHABET_SIZE = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_BAD   = 2'd1,
		STATUS_SHORT = 2'd2
	} status_t;

	typedef struct packed {
		logic                    step;
		logic                    clear;
		logic                    shift_up;
		logic                    shift_dn;
		logic [SYM_W-1:0]        sym;
		logic [SYM_W-1:0]        wr_sym;
		logic signed [WGT_W-1:0] wr_value;
	} cell_ctl_t;

	// minus infinity is sticky
	function automatic logic signed [SUM_W-1:0] add_weight(
		input logic signed [SUM_W-1:0] acc,
		input logic signed [WGT_W-1:0] w
	);
		logic signed [SUM_W-1:0] w_ext;
		w_ext = {{(SUM_W-WGT_W){w[WGT_W-1]}}, w};
		if (acc == NEG_INF || w == LOG_ZERO) begin
			return NEG_INF;
		end
		return acc + w_ext;
	endfunction

	// motif length clamped to the cell count, minus one (zero for a zero length)
	function automatic logic [POS_W-1:0] eff_km1(input logic [KLEN_W-1:0] ml);
		logic [KLEN_W-1:0] t;
		t = ml - KLEN_W'(1);
		if (ml == '0) begin
			return '0;
		end
		if (ml > KLEN_W'(MAX_MOTIF_LEN)) begin
			return POS_W'(MAX_MOTIF_LEN - 1);
		end
		return t[POS_W-1:0];
	endfunction

endpackage

// File: rtl/pmws_if.sv
interface pmws_item_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     opcode;
	logic [pmws_pkg::POS_W-1:0]               weight_position;
	logic [pmws_pkg::SYM_W-1:0]               weight_symbol;
	logic signed [pmws_pkg::WGT_W-1:0]        weight_value;
	logic [pmws_pkg::SYM_W-1:0]               symbol;
	logic                                     last;

	modport source(output valid, opcode, weight_position, weight_symbol, weight_value,
		symbol, last, input ready);
	modport sink(input valid, opcode, weight_position, weight_symbol, weight_value,
		symbol, last, output ready);
endinterface

interface pmws_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [pmws_pkg::SUM_W-1:0] window_score;
	logic signed [pmws_pkg::SUM_W-1:0] best_score;
	logic [1:0]                        status;
	logic                              is_last;

	modport source(output valid, window_score, best_score, status, is_last, input ready);
	modport sink(input valid, window_score, best_score, status, is_last, output ready);
endinterface

// File: rtl/pmws_cell.sv
module pmws_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pmws_pkg::cell_ctl_t                   ctl,
	input  logic                                  wr_en,
	input  logic                                  live,
	input  logic signed [pmws_pkg::SUM_W-1:0]     sum_lo,
	input  logic signed [pmws_pkg::SUM_W-1:0]     sum_hi,
	output logic signed [pmws_pkg::SUM_W-1:0]     sum_q,
	output logic signed [pmws_pkg::SUM_W-1:0]     sum_next
);

	logic signed [pmws_pkg::WGT_W-1:0] wt_q [pmws_pkg::MAX_ALPHABET];
	logic signed [pmws_pkg::WGT_W-1:0] w;

	// weight column of this motif position
	always_ff @(posedge clk) begin
		if (wr_en) begin
			wt_q[ctl.wr_sym] <= ctl.wr_value;
		end
	end

	always_comb begin
		w        = wt_q[ctl.sym];
		sum_next = pmws_pkg::add_weight(sum_lo, w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else begin
			priority if (ctl.clear) begin
				sum_q <= '0;
			end else if (ctl.step && live) begin
				sum_q <= sum_next;
			end else if (ctl.shift_up) begin
				sum_q <= sum_lo;
			end else if (ctl.shift_dn) begin
				sum_q <= sum_hi;
			end
		end
	end

endmodule

// File: rtl/pwm_motif_window_scan_top.sv
// Position weight matrix scanner.
// items: sink channel. opcode load writes one weight of the table, opcode symbol
// presents one sequence symbol; last marks the end of a sequence.
// results: source channel, at most one word per item: window score, best score
// of the sequence so far, status and is_last.
// Config: cfg_we with cfg_index selects motif_length or alphabet_size; the user must
// write them only while no word is in flight, the block itself does not enforce it.
// Throughput: one item per cycle while no result word is stalled and no realignment
// runs. Each result is registered at the motif-end tap and then in the output word.
// A motif_length write realigns the row of partial sums by one cell per cycle,
// and items.ready stays low until the row is realigned.
// Reset clears the partial sums, counters and best score; the weight table is
// undefined until loaded. A stalled receiver holds results.valid and back
// pressure reaches items.ready in the same cycle; no word is lost.
module pwm_motif_window_scan_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [pmws_pkg::CFG_W-1:0]    cfg_data,
	pmws_item_if.sink                     items,
	pmws_result_if.source                 results
);

	logic [pmws_pkg::KLEN_W-1:0]  ml_q;
	logic [pmws_pkg::ALPHA_W-1:0] as_q;
	logic [pmws_pkg::POS_W-1:0]   km1;
	logic [pmws_pkg::POS_W-1:0]   chain_km1_q;
	logic [pmws_pkg::KLEN_W-1:0]  keff;
	logic [pmws_pkg::KLEN_W-1:0]  seen_q;
	logic [pmws_pkg::KLEN_W-1:0]  seen_next;
	logic                         aborted_q;
	logic                         shifting;
	logic                         en;
	logic                         acc;
	logic                         is_sym;
	logic                         is_load;
	logic                         sym_ok;
	logic                         step;
	logic                         emit;
	pmws_pkg::status_t            kind;
	pmws_pkg::cell_ctl_t          ctl;

	logic signed [pmws_pkg::SUM_W-1:0] sum_q    [pmws_pkg::MAX_MOTIF_LEN];
	logic signed [pmws_pkg::SUM_W-1:0] sum_next [pmws_pkg::MAX_MOTIF_LEN];
	logic signed [pmws_pkg::SUM_W-1:0] sum_lo   [pmws_pkg::MAX_MOTIF_LEN];
	logic signed [pmws_pkg::SUM_W-1:0] sum_hi   [pmws_pkg::MAX_MOTIF_LEN];

	logic                              v_s1;
	logic signed [pmws_pkg::SUM_W-1:0] win_s1;
	pmws_pkg::status_t                 kind_s1;
	logic                              last_s1;

	logic                              out_valid_q;
	logic signed [pmws_pkg::SUM_W-1:0] window_q;
	logic signed [pmws_pkg::SUM_W-1:0] best_out_q;
	pmws_pkg::status_t                 status_q;
	logic                              is_last_q;
	logic signed [pmws_pkg::SUM_W-1:0] best_q;
	logic signed [pmws_pkg::SUM_W-1:0] best_upd;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ml_q <= pmws_pkg::KLEN_W'(1);
			as_q <= pmws_pkg::ALPHA_W'(4);
		end else if (cfg_we) begin
			unique case (pmws_pkg::cfg_index_t'(cfg_index))
				pmws_pkg::CFG_MOTIF_LENGTH:  ml_q <= cfg_data[pmws_pkg::KLEN_W-1:0];
				pmws_pkg::CFG_ALPHABET_SIZE: as_q <= cfg_data[pmws_pkg::ALPHA_W-1:0];
			endcase
		end
	end

	always_comb begin
		km1       = pmws_pkg::eff_km1(ml_q);
		keff      = {1'b0, km1} + pmws_pkg::KLEN_W'(1);
		shifting  = chain_km1_q != km1;
		en        = !out_valid_q || results.ready;
		items.ready = en && !shifting;
		acc       = items.valid && items.ready;
		is_sym    = acc && (items.opcode == pmws_pkg::OP_SYMBOL);
		is_load   = acc && (items.opcode == pmws_pkg::OP_LOAD);
		sym_ok    = {1'b0, items.symbol} < as_q;
		step      = is_sym && !aborted_q && sym_ok;
		seen_next = (seen_q < keff) ? seen_q + pmws_pkg::KLEN_W'(1) : seen_q;

		emit = 1'b0;
		kind = pmws_pkg::STATUS_OK;
		if (is_sym) begin
			if (aborted_q) begin
				emit = items.last;
				kind = pmws_pkg::STATUS_BAD;
			end else if (!sym_ok) begin
				emit = 1'b1;
				kind = pmws_pkg::STATUS_BAD;
			end else if (seen_next >= keff) begin
				emit = 1'b1;
				kind = pmws_pkg::STATUS_OK;
			end else begin
				emit = items.last;
				kind = pmws_pkg::STATUS_SHORT;
			end
		end

		ctl.step     = step;
		ctl.clear    = is_sym && items.last;
		ctl.shift_up = shifting && (km1 > chain_km1_q);
		ctl.shift_dn = shifting && (km1 < chain_km1_q);
		ctl.sym      = items.symbol;
		ctl.wr_sym   = items.weight_symbol;
		ctl.wr_value = items.weight_value;
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			aborted_q   <= 1'b0;
			chain_km1_q <= '0;
		end else begin
			if (is_sym && items.last) begin
				seen_q    <= '0;
				aborted_q <= 1'b0;
			end else begin
				if (step) begin
					seen_q <= seen_next;
				end
				if (is_sym && !aborted_q && !sym_ok) begin
					aborted_q <= 1'b1;
				end
			end
			if (ctl.shift_up) begin
				chain_km1_q <= chain_km1_q + pmws_pkg::POS_W'(1);
			end else if (ctl.shift_dn) begin
				chain_km1_q <= chain_km1_q - pmws_pkg::POS_W'(1);
			end
		end
	end

	// row of cells, one per motif position; the row wraps around while it realigns
	for (genvar p = 0; p < pmws_pkg::MAX_MOTIF_LEN; p++) begin : g_cell
		if (p == 0) begin : g_lo0
			assign sum_lo[p] = shifting ? sum_q[pmws_pkg::MAX_MOTIF_LEN-1] : '0;
		end else begin : g_lo
			assign sum_lo[p] = sum_q[p-1];
		end
		if (p == pmws_pkg::MAX_MOTIF_LEN - 1) begin : g_hi0
			assign sum_hi[p] = sum_q[0];
		end else begin : g_hi
			assign sum_hi[p] = sum_q[p+1];
		end

		pmws_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_en    (is_load && (items.weight_position == pmws_pkg::POS_W'(p))),
			.live     (pmws_pkg::POS_W'(p) < km1),
			.sum_lo   (sum_lo[p]),
			.sum_hi   (sum_hi[p]),
			.sum_q    (sum_q[p]),
			.sum_next (sum_next[p])
		);
	end

	// tap the cell at the motif end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win_s1  <= sum_next[km1];
			kind_s1 <= kind;
			last_s1 <= items.last;
		end
	end

	// running best and output word
	always_comb begin
		best_upd = best_q;
		if (kind_s1 == pmws_pkg::STATUS_OK && win_s1 > best_q) begin
			best_upd = win_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			best_q      <= pmws_pkg::NEG_INF;
		end else if (en) begin
			out_valid_q <= v_s1;
			if (v_s1) begin
				best_q <= last_s1 ? pmws_pkg::NEG_INF : best_upd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q  <= kind_s1;
			is_last_q <= last_s1;
			unique case (kind_s1)
				pmws_pkg::STATUS_OK: begin
					window_q   <= win_s1;
					best_out_q <= best_upd;
				end
				pmws_pkg::STATUS_BAD: begin
					window_q   <= pmws_pkg::NEG_INF;
					best_out_q <= best_q;
				end
				default: begin
					window_q   <= pmws_pkg::NEG_INF;
					best_out_q <= pmws_pkg::NEG_INF;
				end
			endcase
		end
	end

	assign results.valid        = out_valid_q;
	assign results.window_score = window_q;
	assign results.best_score   = best_out_q;
	assign results.status       = status_q;
	assign results.is_last      = is_last_q;

endmodule
